>>> rtl/base64_encode_fnv_checksum_top_defines.svh
// Assertion helpers for the RTL files (included by b64f_dp)
`ifndef BASE64_ENCODE_FNV_CHECKSUM_TOP_DEFINES_SVH
`define BASE64_ENCODE_FNV_CHECKSUM_TOP_DEFINES_SVH

// clocked check, off while reset is held
`define B64F_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check that also runs through reset
`define B64F_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

>>> rtl/b64f_pkg.sv
`default_nettype none

package b64f_pkg;

    localparam logic [63:0] FNV_BASIS      = 64'h1465_0FB0_739D_0383;
    // prime = 2^40 + 0x1B3
    localparam int unsigned FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]  FNV_PRIME_LO   = 9'h1B3;

    localparam logic [7:0]  CHAR_PAD   = 8'h3D;
    localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [7:0]  CHAR_SLASH = 8'h2F;
    localparam logic [7:0]  CHAR_UP_A  = 8'h41;
    localparam logic [7:0]  CHAR_LO_A  = 8'h61;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;

    localparam int unsigned CHAR_BUF_DEPTH = 5;
    localparam int unsigned CHAR_CNT_W     = 3;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2,
        PH_X = 2'd3
    } t_phase;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic new_cnt_zero;
        logic new_last;
        logic cnt_one;
        logic last_r;
        logic out_free;
    } t_sts;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return CHAR_UP_A + w;
        end else if (v < 6'd52) begin
            return CHAR_LO_A + w - 8'd26;
        end else if (v < 6'd62) begin
            return CHAR_ZERO + w - 8'd52;
        end else if (v == 6'd62) begin
            return CHAR_PLUS;
        end
        return CHAR_SLASH;
    endfunction

endpackage

`default_nettype wire

>>> rtl/b64f_in_if.sv
`default_nettype none

interface b64f_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/b64f_out_if.sv
`default_nettype none

interface b64f_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

`default_nettype wire

>>> rtl/b64f_ctrl.sv
`default_nettype none

module b64f_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire b64f_pkg::t_sts i_sts,
    output b64f_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.load = in_fire;
        o_cmd.step = (r_state == S_HASH);
        o_cmd.emit = (r_state == S_EMIT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (!i_sts.new_cnt_zero) begin
                        n_state = S_HASH;
                    end else if (i_sts.new_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_HASH: begin
                if (i_sts.cnt_one) begin
                    n_state = i_sts.last_r ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/b64f_dp.sv
`default_nettype none

`include "base64_encode_fnv_checksum_top_defines.svh"

module b64f_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_has_byte,
    input  wire logic           i_last,
    input  wire b64f_pkg::t_cmd i_cmd,
    output b64f_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [63:0]         o_checksum
);

    localparam int unsigned DEPTH = b64f_pkg::CHAR_BUF_DEPTH;
    localparam int unsigned CW    = b64f_pkg::CHAR_CNT_W;

    logic [63:0]        r_hash;
    b64f_pkg::t_phase   r_phase;
    logic [3:0]         r_left;
    logic [7:0]         r_buf [DEPTH];
    logic [CW-1:0]      r_cnt;
    logic               r_last;
    logic               r_out_valid;
    logic [63:0]        r_checksum;

    b64f_pkg::t_phase   n_phase;
    logic [3:0]         n_left;
    logic [7:0]         n_buf [DEPTH];
    logic [CW-1:0]      n_cnt;

    logic [63:0]        x;
    logic [63:0]        n_hash;
    logic               out_free;

    // characters produced by the incoming word, in text order
    always_comb begin
        b64f_pkg::t_phase ph;
        logic [CW-1:0]    k;
        ph      = (r_phase == b64f_pkg::PH_1 || r_phase == b64f_pkg::PH_2) ?
                  r_phase : b64f_pkg::PH_0;
        n_phase = ph;
        n_left  = r_left;
        k       = '0;
        for (int i = 0; i < DEPTH; i++) begin
            n_buf[i] = '0;
        end
        if (i_has_byte) begin
            unique case (ph)
                b64f_pkg::PH_1: begin
                    n_buf[k] = b64f_pkg::b64_char({r_left[1:0], i_data_byte[7:4]});
                    k        = k + 1'b1;
                    n_left   = i_data_byte[3:0];
                    n_phase  = b64f_pkg::PH_2;
                end
                b64f_pkg::PH_2: begin
                    n_buf[k] = b64f_pkg::b64_char({r_left, i_data_byte[7:6]});
                    k        = k + 1'b1;
                    n_buf[k] = b64f_pkg::b64_char(i_data_byte[5:0]);
                    k        = k + 1'b1;
                    n_left   = '0;
                    n_phase  = b64f_pkg::PH_0;
                end
                default: begin
                    n_buf[k] = b64f_pkg::b64_char(i_data_byte[7:2]);
                    k        = k + 1'b1;
                    n_left   = {2'b00, i_data_byte[1:0]};
                    n_phase  = b64f_pkg::PH_1;
                end
            endcase
        end
        if (i_last) begin
            unique case (n_phase)
                b64f_pkg::PH_1: begin
                    n_buf[k] = b64f_pkg::b64_char({n_left[1:0], 4'b0000});
                    k        = k + 1'b1;
                    n_buf[k] = b64f_pkg::CHAR_PAD;
                    k        = k + 1'b1;
                    n_buf[k] = b64f_pkg::CHAR_PAD;
                    k        = k + 1'b1;
                end
                b64f_pkg::PH_2: begin
                    n_buf[k] = b64f_pkg::b64_char({n_left, 2'b00});
                    k        = k + 1'b1;
                    n_buf[k] = b64f_pkg::CHAR_PAD;
                    k        = k + 1'b1;
                end
                default: begin
                end
            endcase
        end
        n_cnt = k;
    end

    // one FNV-1a round: multiply by 2^40 + 0x1B3
    assign x      = r_hash ^ {56'd0, r_buf[0]};
    assign n_hash = (x << b64f_pkg::FNV_PRIME_SHIFT) + 64'(x * b64f_pkg::FNV_PRIME_LO);

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.new_cnt_zero = (n_cnt == '0);
        o_sts.new_last     = i_last;
        o_sts.cnt_one      = (r_cnt == CW'(1));
        o_sts.last_r       = r_last;
        o_sts.out_free     = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= b64f_pkg::FNV_BASIS;
            r_phase     <= b64f_pkg::PH_0;
            r_left      <= '0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_cnt   <= n_cnt;
                r_last  <= i_last;
            end else if (i_cmd.step) begin
                r_hash <= n_hash;
                r_cnt  <= r_cnt - 1'b1;
            end else if (i_cmd.emit) begin
                r_hash  <= b64f_pkg::FNV_BASIS;
                r_phase <= b64f_pkg::PH_0;
                r_left  <= '0;
                r_last  <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_buf[i] <= n_buf[i];
            end
        end else if (i_cmd.step) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_buf[DEPTH-1] <= '0;
        end
        if (i_cmd.emit) begin
            r_checksum <= r_hash;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_checksum  = r_checksum;

    `B64F_ASSERT(a_step_needs_char, i_cmd.step |-> r_cnt != '0, "hash step with no char")
    `B64F_ASSERT(a_load_when_drained, i_cmd.load |-> r_cnt == '0, "load over pending chars")
    `B64F_ASSERT(a_emit_drained, i_cmd.emit |-> r_cnt == '0 && !i_cmd.step, "emit too early")
    `B64F_ASSERT(a_emit_restarts, i_cmd.emit |=> r_out_valid && r_hash == b64f_pkg::FNV_BASIS && r_phase == b64f_pkg::PH_0, "emit did not restart")
    `B64F_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule

`default_nettype wire

>>> rtl/base64_encode_fnv_checksum_top.sv
`default_nettype none

// Base64 text checksum: hashes the padded base64 encoding of a byte message
// with 64-bit FNV-1a and returns the hash when the message ends.
// i_in  : one word per message byte (data_byte, has_byte) plus last. A word
//         with has_byte low and last low is ignored; has_byte low with last
//         high ends the message without adding a byte (empty message gives
//         the FNV offset basis).
// o_out : one checksum word per message, after its last input word.
// Timing: a word is taken only while the block is idle, then each base64
//         character it completes gets its own hash step (one 64x9 multiply
//         and shift-add); a byte completes one or two characters. A last word
//         adds up to 3 flush characters, then the hash is loaded into the
//         result register, which drives the checksum.
// Stall:  the result sits in an output register; the next message is taken
//         meanwhile and only its own result waits until the register frees.
// Reset:  i_rst_n low (synchronous) drops any partial message and result.
module base64_encode_fnv_checksum_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    b64f_in_if.sink   i_in,
    b64f_out_if.source o_out
);

    b64f_pkg::t_cmd cmd;
    b64f_pkg::t_sts sts;

    b64f_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    b64f_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in.data_byte),
        .i_has_byte  (i_in.has_byte),
        .i_last      (i_in.last),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_checksum  (o_out.checksum)
    );

endmodule

`default_nettype wire

>>> verif/base64_encode_fnv_checksum_top_tb.sv
`default_nettype none

module base64_encode_fnv_checksum_top_tb;

    localparam logic [63:0] FNV_OFFSET = 64'h1465_0FB0_739D_0383;
    localparam logic [63:0] FNV_MULT   = 64'h0000_0100_0000_01B3;
    localparam logic [7:0]  PAD_CHAR   = 8'h3D;
    localparam logic [7:0]  PLUS_CHAR  = 8'h2B;
    localparam logic [7:0]  SLASH_CHAR = 8'h2F;
    localparam int          WORDS_PER_PHASE = 150;
    localparam int          NUM_PHASES      = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } msg_word_t;

    logic clk;
    logic rst_n;

    b64f_in_if  in_ch ();
    b64f_out_if out_ch ();

    base64_encode_fnv_checksum_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    msg_word_t   pending_words[$];
    logic [63:0] sums_due[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          errors;

    // encoder state mirror
    logic [63:0] hash_acc;
    logic [1:0]  grp_phase;
    logic [3:0]  carry_bits;

    msg_word_t   next_word;
    logic [63:0] want_sum;

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        if (v < 6'd26) begin
            return 8'h41 + 8'(v);
        end else if (v < 6'd52) begin
            return 8'h61 + 8'(v - 6'd26);
        end else if (v < 6'd62) begin
            return 8'h30 + 8'(v - 6'd52);
        end else if (v == 6'd62) begin
            return PLUS_CHAR;
        end
        return SLASH_CHAR;
    endfunction

    task automatic fold_char(input logic [7:0] c);
        hash_acc = (hash_acc ^ {56'd0, c}) * FNV_MULT;
    endtask

    task automatic clear_encoder();
        hash_acc   = FNV_OFFSET;
        grp_phase  = 2'd0;
        carry_bits = 4'd0;
    endtask

    task automatic absorb_word(input logic [7:0] b, input logic has, input logic fin);
        if (has) begin
            case (grp_phase)
                2'd1: begin
                    fold_char(b64_symbol({carry_bits[1:0], b[7:4]}));
                    carry_bits = b[3:0];
                    grp_phase  = 2'd2;
                end
                2'd2: begin
                    fold_char(b64_symbol({carry_bits, b[7:6]}));
                    fold_char(b64_symbol(b[5:0]));
                    carry_bits = 4'd0;
                    grp_phase  = 2'd0;
                end
                default: begin
                    fold_char(b64_symbol(b[7:2]));
                    carry_bits = {2'b00, b[1:0]};
                    grp_phase  = 2'd1;
                end
            endcase
        end
        if (fin) begin
            if (grp_phase == 2'd1) begin
                fold_char(b64_symbol({carry_bits[1:0], 4'b0000}));
                fold_char(PAD_CHAR);
                fold_char(PAD_CHAR);
            end else if (grp_phase == 2'd2) begin
                fold_char(b64_symbol({carry_bits, 2'b00}));
                fold_char(PAD_CHAR);
            end
            sums_due.push_back(hash_acc);
            clear_encoder();
        end
    endtask

    task automatic push_word(input logic [7:0] b, input logic has, input logic fin);
        msg_word_t w;
        w.data_byte = b;
        w.has_byte  = has;
        w.last      = fin;
        pending_words.push_back(w);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // queues one message, returns the number of words that are not ignored
    task automatic queue_message(input int nbytes, output int used);
        logic bare_end;
        bare_end = (nbytes == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            push_word(pick_byte(), 1'b1, !bare_end && (i == nbytes - 1));
        end
        if (bare_end) begin
            push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        used = nbytes + (bare_end ? 1 : 0);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_ch.valid || sums_due.size() != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data_byte = 8'd0;
        in_ch.has_byte = 1'b0;
        in_ch.last     = 1'b0;
        out_ch.ready   = 1'b0;
        fork
            forever #5 clk = ~clk;
            begin
                repeat (4) @(posedge clk);
                rst_n <= 1'b1;
            end
        join
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // input driver, predicts on every accepted word
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            clear_encoder();
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_word(in_ch.data_byte, in_ch.has_byte, in_ch.last);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_word = pending_words.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= next_word.data_byte;
                    in_ch.has_byte  <= next_word.has_byte;
                    in_ch.last      <= next_word.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (sums_due.size() == 0) begin
                    $display("%0t: unexpected checksum: expected none, actual %h",
                             $time, out_ch.checksum);
                    errors++;
                end else begin
                    want_sum = sums_due.pop_front();
                    if (out_ch.checksum !== want_sum) begin
                        $display("%0t: checksum mismatch: expected %h, actual %h",
                                 $time, want_sum, out_ch.checksum);
                        errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        int idle_tab[NUM_PHASES];
        int stall_tab[NUM_PHASES];
        int taken;
        int used;
        int nbytes;

        idle_tab  = '{0, 88, 0, 17};
        stall_tab = '{0, 0, 88, 17};
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        @(negedge clk);
        // empty message, then an ignored word
        push_word(8'h00, 1'b0, 1'b1);
        push_word(8'hA5, 1'b0, 1'b0);
        // one byte with last: two pad chars
        push_word(8'h00, 1'b1, 1'b1);
        // two bytes: one pad char
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'hFF, 1'b1, 1'b1);
        // '+' and '/' in a full group
        push_word(8'hFB, 1'b1, 1'b0);
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'hBF, 1'b1, 1'b1);
        // bare end after one byte
        push_word(8'h80, 1'b1, 1'b0);
        push_word(8'hFF, 1'b0, 1'b1);
        // ignored word inside a message, bare end after two bytes
        push_word(8'h4D, 1'b1, 1'b0);
        push_word(8'h61, 1'b1, 1'b0);
        push_word(8'h5A, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);
        // bare end right after a full group
        push_word(8'h4D, 1'b1, 1'b0);
        push_word(8'h61, 1'b1, 1'b0);
        push_word(8'h6E, 1'b1, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);
        // full group then one byte with last
        push_word(8'h00, 1'b1, 1'b0);
        push_word(8'h1F, 1'b1, 1'b0);
        push_word(8'h7F, 1'b1, 1'b0);
        push_word(8'hC0, 1'b1, 1'b1);
        // back-to-back empty messages
        push_word(8'h33, 1'b0, 1'b1);
        push_word(8'hCC, 1'b0, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            taken = 0;
            while (taken < WORDS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    nbytes = $urandom_range(7, 48);
                end else begin
                    nbytes = $urandom_range(0, 6);
                end
                queue_message(nbytes, used);
                taken += used;
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (errors == 0 && sums_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/b64f_pkg.sv
rtl/b64f_in_if.sv
rtl/b64f_out_if.sv
rtl/b64f_ctrl.sv
rtl/b64f_dp.sv
rtl/base64_encode_fnv_checksum_top.sv
verif/base64_encode_fnv_checksum_top_tb.sv
